>>> rtl/core/efsp_pkg.sv
// Shared types and constants of the event frame sync parser.
package efsp_pkg;

    localparam int DEF_SCAN_WINDOW = 16;
    localparam int DEF_RAW_LIMIT   = 64;
    localparam int DEF_QUEUE_DEPTH = 4;

    localparam int          CAP_W          = 9;
    localparam int          LEFT_W         = 9;
    localparam int          MAX_RESULTS    = 3;
    localparam logic [8:0]  RESET_CAPACITY = 9'd32;
    localparam logic [8:0]  MIN_CAPACITY   = 9'd4;
    localparam logic [7:0]  SYNC_BYTE      = 8'hA5;
    localparam logic [7:0]  EVENT_LO       = 8'h81;
    localparam logic [7:0]  EVENT_HI       = 8'h87;
    localparam int          FRAME_OVERHEAD = 4;
    localparam int          HEADER_LEN     = 3;

    typedef enum logic [2:0] {
        ST_RUNNING   = 3'd0,
        ST_OK        = 3'd1,
        ST_BAD_SUM   = 3'd2,
        ST_TOO_LONG  = 3'd3,
        ST_NO_SYNC   = 3'd4,
        ST_CAP_SMALL = 3'd5
    } t_status;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       byte_valid;
        logic       read_done;
        t_status    status;
    } t_result;

    // All results caused by one input transaction.
    typedef struct packed {
        logic [1:0]   count;
        t_result [2:0] res;
    } t_record;

    // Scanner state, less the byte counter whose width follows the window.
    typedef struct packed {
        logic [7:0]        older_byte;
        logic [7:0]        newer_byte;
        logic              sync_found;
        logic [LEFT_W-1:0] bytes_left;
        logic [7:0]        running_sum;
        logic              read_finished;
    } t_scan;

endpackage

>>> rtl/core/event_frame_sync_parser_core.sv
// Top level of the event frame sync parser: scanner state, config register, result queue.
// A transaction's results are registered in the result queue before any of them is offered.
// One input transaction per cycle while the result queue has room; a located header gives
//   three results, and the result port (one per cycle while the receiver is ready) sets the pace.
// The result queue holds four records; input ready drops only when it is full.
// Reset (synchronous, active low): capacity 32, scanner cleared, read marked finished
//   so bytes are ignored until one arrives with first_of_read set.
module event_frame_sync_parser_core #(
    parameter int SCAN_WINDOW = efsp_pkg::DEF_SCAN_WINDOW,
    parameter int RAW_LIMIT   = efsp_pkg::DEF_RAW_LIMIT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration: frame capacity in bytes
    input  logic                       i_cfg_we,
    input  logic [efsp_pkg::CAP_W-1:0] i_cfg_data,
    // received bytes
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_first_of_read,
    input  logic [7:0]                 i_rx_byte,
    // frame bytes and status
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [7:0]                 o_frame_byte,
    output logic                       o_byte_valid,
    output logic                       o_read_done,
    output logic [2:0]                 o_status
);
    import efsp_pkg::*;

    localparam int SEEN_W = $clog2(SCAN_WINDOW + 1);

    logic [CAP_W-1:0]  r_capacity;
    t_scan             r_scan;
    logic [SEEN_W-1:0] r_seen;
    t_scan             n_scan;
    logic [SEEN_W-1:0] n_seen;
    t_record           step_rec;
    t_result           q_res;
    logic              accept;
    logic              q_space;

    // Accept whenever the queue can hold one more record, even with a result waiting.
    assign o_ready = q_space;
    assign accept  = i_valid && o_ready;

    // Hold the capacity register; it is sampled when a read opens and when a header is judged.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= RESET_CAPACITY;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_data;
        end
    end

    // Per-byte decision: clear on a first byte, count the scan window, find the
    // header, then count down payload and checksum while summing.
    efsp_step #(
        .SCAN_WINDOW (SCAN_WINDOW),
        .RAW_LIMIT   (RAW_LIMIT),
        .SEEN_W      (SEEN_W)
    ) u_step (
        .i_first_of_read (i_first_of_read),
        .i_rx_byte       (i_rx_byte),
        .i_capacity      (r_capacity),
        .i_state         (r_scan),
        .i_seen          (r_seen),
        .o_state         (n_scan),
        .o_seen          (n_seen),
        .o_record        (step_rec)
    );

    // Advance scanner state only on an accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '{older_byte: '0, newer_byte: '0, sync_found: 1'b0,
                        bytes_left: '0, running_sum: '0, read_finished: 1'b1};
            r_seen <= '0;
        end else if (accept) begin
            r_scan <= n_scan;
            r_seen <= n_seen;
        end
    end

    // Queue only transactions that produce results; ignored bytes drop here.
    efsp_outq #(
        .DEPTH (DEF_QUEUE_DEPTH)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && (step_rec.count != 2'd0)),
        .i_rec   (step_rec),
        .o_space (q_space),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (q_res)
    );

    assign o_frame_byte = q_res.frame_byte;
    assign o_byte_valid = q_res.byte_valid;
    assign o_read_done  = q_res.read_done;
    assign o_status     = q_res.status;

    a_finish_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (step_rec.count != 2'd0) && step_rec.res[0].read_done)
        |=> r_scan.read_finished)
        else $error("read done reported but scanner still running");

    a_idle_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_scan.read_finished && !i_first_of_read) |-> (step_rec.count == 2'd0))
        else $error("result produced after read finished");

    a_seen_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= SEEN_W'(SCAN_WINDOW))
        else $error("byte counter beyond scan window");

endmodule

>>> rtl/core/efsp_step.sv
// Next-state and result logic for one received byte.
module efsp_step #(
    parameter int SCAN_WINDOW = efsp_pkg::DEF_SCAN_WINDOW,
    parameter int RAW_LIMIT   = efsp_pkg::DEF_RAW_LIMIT,
    parameter int SEEN_W      = $clog2(SCAN_WINDOW + 1)
) (
    input  logic                     i_first_of_read,
    input  logic [7:0]               i_rx_byte,
    input  logic [efsp_pkg::CAP_W-1:0] i_capacity,
    input  efsp_pkg::t_scan          i_state,
    input  logic [SEEN_W-1:0]        i_seen,
    output efsp_pkg::t_scan          o_state,
    output logic [SEEN_W-1:0]        o_seen,
    output efsp_pkg::t_record        o_record
);
    import efsp_pkg::*;

    localparam int CMP_W = $clog2(SCAN_WINDOW + RAW_LIMIT + 260);

    t_scan             cur;
    logic [SEEN_W-1:0] seen;
    logic [SEEN_W-1:0] seen_inc;
    logic [LEFT_W-1:0] left_dec;
    logic [CMP_W-1:0]  total;
    logic [CMP_W-1:0]  pos;
    logic              hdr_hit;

    always_comb begin
        cur  = i_state;
        seen = i_seen;
        // A first byte restarts the scanner before it is looked at.
        if (i_first_of_read) begin
            cur  = '0;
            seen = '0;
        end

        o_state  = cur;
        o_seen   = seen;
        o_record = '0;

        seen_inc = seen + SEEN_W'(1);
        left_dec = cur.bytes_left - LEFT_W'(1);
        total    = CMP_W'(i_rx_byte) + CMP_W'(FRAME_OVERHEAD);
        pos      = CMP_W'(seen_inc) - CMP_W'(HEADER_LEN);
        hdr_hit  = (seen_inc >= SEEN_W'(HEADER_LEN)) && (seen_inc <= SEEN_W'(SCAN_WINDOW))
                   && (cur.older_byte == SYNC_BYTE)
                   && (cur.newer_byte >= EVENT_LO) && (cur.newer_byte <= EVENT_HI);

        if (i_first_of_read && (i_capacity < MIN_CAPACITY)) begin
            o_record.count  = 2'd1;
            o_record.res[0] = '{8'd0, 1'b0, 1'b1, ST_CAP_SMALL};
            o_state.read_finished = 1'b1;
        end else if (!i_first_of_read && cur.read_finished) begin
            o_record = '0;
        end else if (cur.sync_found) begin
            o_state.bytes_left = left_dec;
            o_record.count     = 2'd1;
            if (left_dec == '0) begin
                o_record.res[0] = '{i_rx_byte, 1'b1, 1'b1,
                                    (i_rx_byte == cur.running_sum) ? ST_OK : ST_BAD_SUM};
                o_state.read_finished = 1'b1;
            end else begin
                o_state.running_sum = cur.running_sum + i_rx_byte;
                o_record.res[0]     = '{i_rx_byte, 1'b1, 1'b0, ST_RUNNING};
            end
        end else begin
            o_seen = seen_inc;
            if (hdr_hit) begin
                if ((total > CMP_W'(i_capacity)) || ((pos + total) > CMP_W'(RAW_LIMIT))) begin
                    o_record.count  = 2'd1;
                    o_record.res[0] = '{8'd0, 1'b0, 1'b1, ST_TOO_LONG};
                    o_state.read_finished = 1'b1;
                end else begin
                    o_record.count  = 2'd3;
                    o_record.res[0] = '{cur.older_byte, 1'b1, 1'b0, ST_RUNNING};
                    o_record.res[1] = '{cur.newer_byte, 1'b1, 1'b0, ST_RUNNING};
                    o_record.res[2] = '{i_rx_byte, 1'b1, 1'b0, ST_RUNNING};
                    o_state.running_sum = cur.older_byte + cur.newer_byte + i_rx_byte;
                    o_state.bytes_left  = LEFT_W'(i_rx_byte) + LEFT_W'(1);
                    o_state.sync_found  = 1'b1;
                end
            end else begin
                o_state.older_byte = cur.newer_byte;
                o_state.newer_byte = i_rx_byte;
                if (seen_inc >= SEEN_W'(SCAN_WINDOW)) begin
                    o_record.count  = 2'd1;
                    o_record.res[0] = '{8'd0, 1'b0, 1'b1, ST_NO_SYNC};
                    o_state.read_finished = 1'b1;
                end
            end
        end
    end

endmodule

>>> rtl/core/efsp_outq.sv
// Result queue: holds per-transaction records and hands out one result a cycle while the receiver is ready.
module efsp_outq #(
    parameter int DEPTH = efsp_pkg::DEF_QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  efsp_pkg::t_record i_rec,
    output logic              o_space,
    output logic              o_valid,
    input  logic              i_ready,
    output efsp_pkg::t_result o_res
);
    import efsp_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);

    t_record            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [PTR_W:0]     r_count;
    logic [1:0]         r_sub;
    t_record            head;
    logic               take;
    logic               pop;

    assign head    = r_mem[r_rd_ptr];
    assign o_valid = (r_count != '0);
    assign o_space = (r_count < (PTR_W + 1)'(DEPTH));
    assign o_res   = head.res[r_sub];
    assign take    = o_valid && i_ready;
    assign pop     = take && (r_sub == (head.count - 2'd1));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_sub    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
                r_sub    <= '0;
            end else if (take) begin
                r_sub <= r_sub + 2'd1;
            end
            r_count <= r_count + (PTR_W + 1)'(i_push) - (PTR_W + 1)'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (PTR_W + 1)'(DEPTH))
        else $error("result queue count beyond depth");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (o_space || pop))
        else $error("record pushed into full queue");

    a_sub_in_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_sub < head.count))
        else $error("result index past end of record");

    a_sub_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> (r_sub == 2'd0))
        else $error("result index left nonzero on empty queue");

endmodule

>>> tb/event_frame_sync_parser_core_tb.sv
// Testbench for the event frame sync parser: predicts frame bytes and status, checks in order.
module event_frame_sync_parser_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import efsp_pkg::*;

    // Stop offering new reads once this many bytes have been accepted.
    localparam int ITEM_GOAL     = 430;
    // Cycles with no transaction on either side before the run is declared hung.
    localparam int IDLE_LIMIT    = 2000;
    // Cycles to let pass after the last due result, before a capacity write or the end.
    localparam int SETTLE_CYCLES = 4;
    // Length of the one long receiver hold-off that fills the result queue.
    localparam int LONG_HOLD     = 80;

    // Receiver stall patterns.
    typedef enum int {
        FLOW_FREE,
        FLOW_LIGHT,
        FLOW_HEAVY,
        FLOW_PERIODIC
    } t_flow;

    // Tracks the parser's scanner and frame state, and holds the results each
    // accepted byte is due to produce until the block delivers them.
    class frame_parse_checker;
        logic [CAP_W-1:0]  capacity;
        logic [7:0]        older_byte;
        logic [7:0]        newer_byte;
        int                bytes_seen;
        logic              synced;
        logic [LEFT_W-1:0] bytes_left;
        logic [7:0]        running_sum;
        logic              finished;
        t_result           frame_results_due[$];
        int                errors;

        function new();
            capacity = RESET_CAPACITY;
            clear_scan();
            finished = 1'b1;
            errors   = 0;
        endfunction

        function void clear_scan();
            older_byte  = '0;
            newer_byte  = '0;
            bytes_seen  = 0;
            synced      = 1'b0;
            bytes_left  = '0;
            running_sum = '0;
        endfunction

        function void add_result(logic [7:0] fb, logic bv, logic rd, t_status st);
            t_result r;
            r.frame_byte = fb;
            r.byte_valid = bv;
            r.read_done  = rd;
            r.status     = st;
            frame_results_due.push_back(r);
        endfunction

        function int pending();
            return frame_results_due.size();
        endfunction

        // Predict the results of one accepted byte; returns 0 when the byte is ignored.
        function bit note_byte(logic first, logic [7:0] b);
            int total;
            if (first) begin
                clear_scan();
                finished = 1'b0;
                if (capacity < MIN_CAPACITY) begin
                    add_result(8'h00, 1'b0, 1'b1, ST_CAP_SMALL);
                    finished = 1'b1;
                    return 1'b1;
                end
            end else if (finished) begin
                return 1'b0;
            end

            if (synced) begin
                bytes_left = bytes_left - 1'b1;
                if (bytes_left == 0) begin
                    if (b == running_sum) add_result(b, 1'b1, 1'b1, ST_OK);
                    else add_result(b, 1'b1, 1'b1, ST_BAD_SUM);
                    finished = 1'b1;
                end else begin
                    running_sum = running_sum + b;
                    add_result(b, 1'b1, 1'b0, ST_RUNNING);
                end
                return 1'b1;
            end

            if (bytes_seen < 2047) bytes_seen++;

            if (bytes_seen >= HEADER_LEN && bytes_seen <= DEF_SCAN_WINDOW &&
                older_byte == SYNC_BYTE && newer_byte >= EVENT_LO && newer_byte <= EVENT_HI) begin
                total = FRAME_OVERHEAD + b;
                if (total > capacity || bytes_seen - HEADER_LEN + total > DEF_RAW_LIMIT) begin
                    add_result(8'h00, 1'b0, 1'b1, ST_TOO_LONG);
                    finished = 1'b1;
                    return 1'b1;
                end
                add_result(older_byte, 1'b1, 1'b0, ST_RUNNING);
                add_result(newer_byte, 1'b1, 1'b0, ST_RUNNING);
                add_result(b, 1'b1, 1'b0, ST_RUNNING);
                running_sum = older_byte + newer_byte + b;
                bytes_left  = b + 9'd1;
                synced      = 1'b1;
                return 1'b1;
            end

            older_byte = newer_byte;
            newer_byte = b;
            if (bytes_seen >= DEF_SCAN_WINDOW) begin
                add_result(8'h00, 1'b0, 1'b1, ST_NO_SYNC);
                finished = 1'b1;
            end
            return 1'b1;
        endfunction

        function void check_result(logic [7:0] fb, logic bv, logic rd, logic [2:0] st);
            t_result want;
            if (frame_results_due.size() == 0) begin
                $error("no result due: frame_byte %0h byte_valid %0b read_done %0b status %0d",
                       fb, bv, rd, st);
                errors++;
                return;
            end
            want = frame_results_due.pop_front();
            if (fb !== want.frame_byte) begin
                $error("frame_byte: expected %0h, actual %0h", want.frame_byte, fb);
                errors++;
            end
            if (bv !== want.byte_valid) begin
                $error("byte_valid: expected %0b, actual %0b", want.byte_valid, bv);
                errors++;
            end
            if (rd !== want.read_done) begin
                $error("read_done: expected %0b, actual %0b", want.read_done, rd);
                errors++;
            end
            if (st !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, st);
                errors++;
            end
        endfunction
    endclass

    logic             i_clk           = 1'b0;
    logic             i_rst_n         = 1'b0;
    logic             i_cfg_we        = 1'b0;
    logic [CAP_W-1:0] i_cfg_data      = '0;
    logic             i_valid         = 1'b0;
    logic             o_ready;
    logic             i_first_of_read = 1'b0;
    logic [7:0]       i_rx_byte       = '0;
    logic             o_valid;
    logic             i_ready         = 1'b0;
    logic [7:0]       o_frame_byte;
    logic             o_byte_valid;
    logic             o_read_done;
    logic [2:0]       o_status;

    frame_parse_checker parse_board;
    int                 burst_left   = 0;
    int                 bytes_taken  = 0;
    int                 cur_capacity = RESET_CAPACITY;
    bit                 hold_req     = 1'b0;
    int                 phase_caps [0:8];

    always #1 i_clk = ~i_clk;

    event_frame_sync_parser_core #(
        .SCAN_WINDOW(DEF_SCAN_WINDOW),
        .RAW_LIMIT  (DEF_RAW_LIMIT)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_first_of_read(i_first_of_read),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_frame_byte   (o_frame_byte),
        .o_byte_valid   (o_byte_valid),
        .o_read_done    (o_read_done),
        .o_status       (o_status)
    );

    // Offer one byte and hold it until the transaction completes. The sender works
    // in bursts: at the start of a burst, idle for a random gap; at the end of one,
    // drop valid on the accepting edge. Back-to-back bytes inside a burst keep valid
    // high, so valid is never lowered and raised in the same step.
    task automatic push_byte(input logic first, input logic [7:0] value);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        i_valid         <= 1'b1;
        i_first_of_read <= first;
        i_rx_byte       <= value;
        // Sample ready before this edge's updates land: that is the handshake value.
        do @(posedge i_clk); while (!o_ready);
        void'(parse_board.note_byte(first, value));
        bytes_taken++;
        burst_left--;
        if (burst_left == 0) i_valid <= 1'b0;
    endtask

    // End the current burst early; call only on the edge that accepted the last byte.
    task automatic hold_sender();
        if (burst_left != 0) begin
            i_valid    <= 1'b0;
            burst_left = 0;
        end
    endtask

    // Pause the sender until every due result has come, then let the block settle.
    task automatic drain_results();
        hold_sender();
        while (parse_board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the capacity register with the block idle; a read may still be open.
    task automatic write_capacity(input logic [CAP_W-1:0] value);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        parse_board.capacity = value;
        cur_capacity = value;
    endtask

    // Byte biased toward sync and event codes, to provoke partial headers.
    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 3))
            0:       return SYNC_BYTE;
            1:       return 8'($urandom_range(EVENT_LO, EVENT_HI));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Send lead noise bytes, a header with the given payload length, the payload and
    // the checksum. A nonzero cut truncates the read after that many bytes. With
    // opened set, the read is already under way and no byte carries first_of_read.
    task automatic send_frame_read(input int lead, input int plen, input bit good_sum,
                                   input bit opened, input int cut);
        logic [7:0] sum;
        logic [7:0] b;
        logic       fresh;
        int         span;
        int         k;
        fresh = !opened;
        sum   = '0;
        span  = lead + plen + FRAME_OVERHEAD;
        if (cut != 0 && cut < span) span = cut;
        for (k = 0; k < span; k++) begin
            if (k < lead) b = 8'($urandom_range(0, 255));
            else if (k == lead) b = SYNC_BYTE;
            else if (k == lead + 1) b = 8'($urandom_range(EVENT_LO, EVENT_HI));
            else if (k == lead + 2) b = 8'(plen);
            else if (k < lead + plen + HEADER_LEN) b = 8'($urandom_range(0, 255));
            else if (good_sum) b = sum;
            else b = sum ^ (8'h01 << $urandom_range(0, 7));
            if (k >= lead) sum = sum + b;
            push_byte(fresh, b);
            fresh = 1'b0;
        end
    endtask

    task automatic send_noise_read(input int count);
        int k;
        for (k = 0; k < count; k++) push_byte(k == 0, noise_byte());
    endtask

    // One random read: mostly frames sized to fit (some with a bad checksum), the rest oversized
    // frames, noise, truncated frames and headers that start too late.
    task automatic send_random_read();
        int pick;
        int lead;
        int lim;
        int plen;
        int k;
        pick = $urandom_range(0, 99);
        lead = ($urandom_range(0, 3) == 0) ? $urandom_range(0, DEF_SCAN_WINDOW - HEADER_LEN)
                                           : $urandom_range(0, 3);
        lim = cur_capacity;
        if (DEF_RAW_LIMIT - lead < lim) lim = DEF_RAW_LIMIT - lead;
        lim = lim - FRAME_OVERHEAD;
        if (lim < 0) plen = $urandom_range(0, 3);
        else if ($urandom_range(0, 7) == 0) plen = $urandom_range(0, lim);
        else plen = $urandom_range(0, (lim < 10) ? lim : 10);

        if (pick < 65)
            send_frame_read(lead, plen, $urandom_range(0, 4) != 0, 1'b0, 0);
        else if (pick < 75)
            send_frame_read(lead, $urandom_range(0, 255), 1'b1, 1'b0, 0);
        else if (pick < 85)
            send_noise_read($urandom_range(1, 24));
        else if (pick < 93)
            send_frame_read(lead, plen, 1'b1, 1'b0, $urandom_range(1, lead + plen + HEADER_LEN));
        else
            send_frame_read($urandom_range(DEF_SCAN_WINDOW - 2, DEF_SCAN_WINDOW), plen,
                            1'b1, 1'b0, 0);

        // Trailing bytes without first_of_read: once the read is over, the block must drop them.
        if ($urandom_range(0, 4) == 0)
            for (k = $urandom_range(1, 3); k > 0; k--) push_byte(1'b0, noise_byte());
    endtask

    // Receiver: check every result transaction, then pick ready for the next edge.
    // Ready follows a stall pattern that is picked anew when its random run ends, and once goes low
    // for a long stretch on request so the queue fills and input ready drops.
    initial begin
        t_flow flow;
        int    flow_left;
        int    hold_left;
        int    beat;
        logic  take;
        flow      = FLOW_FREE;
        flow_left = 0;
        hold_left = 0;
        beat      = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready)
                parse_board.check_result(o_frame_byte, o_byte_valid, o_read_done, o_status);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                take = 1'b0;
            end else begin
                if (flow_left == 0) begin
                    flow      = t_flow'($urandom_range(0, 3));
                    flow_left = $urandom_range(4, 48);
                end
                flow_left--;
                beat++;
                case (flow)
                    FLOW_FREE:  take = 1'b1;
                    FLOW_LIGHT: take = ($urandom_range(0, 3) != 0);
                    FLOW_HEAVY: take = ($urandom_range(0, 3) == 0);
                    default:    take = (beat % 5 != 0);
                endcase
            end
            i_ready <= take;
        end
    end

    // Watchdog: end the run when neither side completes a transaction for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) quiet = 0;
            else quiet++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int ph;
        int reads;
        int phase_start;
        bit read_open;
        int k;
        parse_board = new();
        // Bits 0..8 of the capacity each take both values across these.
        phase_caps  = '{259, 32, 3, 100, 4, 0, 80, 5, 200};
        ph          = 0;
        read_open   = 1'b0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part.
        // No read is open after reset: drop this byte.
        push_byte(1'b0, 8'h3C);
        // Open a read with a noise byte, then shrink capacity to its minimum mid-read;
        // the header that follows must be judged against the new value.
        push_byte(1'b1, 8'h5A);
        write_capacity(MIN_CAPACITY);
        // Empty payload, good checksum: A5 + 81 + 00 = 26.
        push_byte(1'b0, SYNC_BYTE);
        push_byte(1'b0, EVENT_LO);
        push_byte(1'b0, 8'h00);
        push_byte(1'b0, 8'h26);
        // Five-byte frame against capacity four: too long; the trailing byte is dropped.
        push_byte(1'b1, SYNC_BYTE);
        push_byte(1'b0, 8'h82);
        push_byte(1'b0, 8'h01);
        push_byte(1'b0, 8'h99);
        write_capacity(9'd259);
        // Top event code, payload FF, checksum off by one (good one is 2C).
        push_byte(1'b1, SYNC_BYTE);
        push_byte(1'b0, EVENT_HI);
        push_byte(1'b0, 8'h01);
        push_byte(1'b0, 8'hFF);
        push_byte(1'b0, 8'h2D);
        // 65-byte frame at the start of the read: over the raw limit.
        push_byte(1'b1, SYNC_BYTE);
        push_byte(1'b0, 8'h83);
        push_byte(1'b0, 8'h3D);
        // Header starting too late to fit in the scan window: no sync.
        for (k = 0; k < DEF_SCAN_WINDOW - 2; k++) push_byte(k == 0, 8'(k));
        push_byte(1'b0, SYNC_BYTE);
        push_byte(1'b0, 8'h85);
        // Capacity zero: the first byte of a read is refused outright.
        write_capacity(9'd0);
        push_byte(1'b1, 8'hFF);

        // Random part, in phases with one capacity each.
        while (bytes_taken < ITEM_GOAL) begin
            write_capacity(CAP_W'(phase_caps[ph % 9]));
            // Fill the block on the first phase: long receiver hold, sender keeps going.
            if (ph == 0) hold_req = 1'b1;
            // Finish a read left open across the capacity write.
            if (read_open)
                send_frame_read($urandom_range(0, 3), $urandom_range(0, 6), 1'b1, 1'b1, 0);
            phase_start = bytes_taken;
            reads       = 0;
            while (bytes_taken < ITEM_GOAL &&
                   ((cur_capacity >= MIN_CAPACITY && bytes_taken - phase_start < 60) ||
                    (cur_capacity < MIN_CAPACITY && reads < 6))) begin
                send_random_read();
                reads++;
                // Hold the sender mid-phase until every due result is in.
                if (reads == 3) drain_results();
            end
            // Sometimes leave a read open for the next capacity write.
            read_open = ($urandom_range(0, 2) == 0);
            if (read_open) push_byte(1'b1, 8'($urandom_range(0, 255)));
            ph++;
        end

        drain_results();
        if (parse_board.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
